// ----- rtl/ptc_pkg.sv -----
// Shared types and constants for the pressure/temperature compensation block.
// Used by ptc_front, ptc_div, ptc_back and the top level; no dependencies.
package ptc_pkg;

  localparam int unsigned RawW     = 20;
  localparam int unsigned CfgW     = 64;
  localparam int unsigned DivW     = 64;  // dividend and quotient width
  localparam int unsigned RemW     = 31;  // divisor magnitude and remainder width
  localparam int unsigned DivSteps = DivW;
  localparam int unsigned FrontLat = 11;
  localparam int unsigned BackLat  = 6;
  localparam int unsigned Latency  = FrontLat + DivSteps + BackLat;

  localparam logic signed [25:0] FINE_OFFSET = 26'sd128000;
  localparam logic [20:0]        PRESS_FULL  = 21'd1048576;
  localparam logic [11:0]        PRESS_SCALE = 12'd3125;
  localparam logic [63:0]        DIV_BIAS    = 64'h0000_8000_0000_0000;
  localparam logic [27:0]        TEMP_ROUND  = 28'd128;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_TEMP       = 2'd0,
    CFG_PRESS_A    = 2'd1,
    CFG_PRESS_B    = 2'd2,
    CFG_PRESS_NINE = 2'd3
  } cfg_idx_e;

  // unpacked calibration coefficients
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } coeff_t;

  // word carried through the divider stages
  typedef struct packed {
    logic [DivW-1:0] dvd;   // dividend bits shift out, quotient bits shift in
    logic [RemW-1:0] dsr;
    logic [RemW-1:0] rem;
    logic            neg;
    logic            zero;
    logic [31:0]     temp;
  } div_word_t;

endpackage

// ----- rtl/ptc_front.sv -----
// Temperature compensation and pressure divisor/dividend pipeline (11 stages).
// Depends on ptc_pkg; feeds ptc_div.
module ptc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  logic [19:0]        raw_pressure_i,
  input  logic [19:0]        raw_temperature_i,
  input  ptc_pkg::coeff_t    coeff_i,
  output logic               vld_o,
  output ptc_pkg::div_word_t word_o
);
  import ptc_pkg::*;

  logic [FrontLat-1:0] vld_q;

  logic [19:0] adc_p0_q, adc_t0_q;
  logic [19:0] adc_p1_q, adc_p2_q, adc_p3_q, adc_p4_q, adc_p5_q, adc_p6_q, adc_p7_q;

  logic signed [17:0] d1;
  logic signed [16:0] d2;
  logic signed [33:0] mt2_d, mt2_q, sqt_d, sqt_q;
  logic signed [21:0] sqs;
  logic signed [37:0] m3t_d, m3t_q;
  logic signed [22:0] at_q;
  logic signed [23:0] bt;
  logic signed [24:0] fine_d, fine_q;
  logic signed [27:0] t5;
  logic [31:0] temp_d, temp4_q, temp5_q, temp6_q, temp7_q, temp8_q, temp9_q;
  logic signed [25:0] pa_d, pa_q;
  logic signed [51:0] sqp_d, sqp_q;
  logic signed [41:0] m5_d, m5_q, m2_d, m2_q;
  logic signed [67:0] m6_full, m3_full;
  logic [63:0] m6_q, m3_q, bpart_d, bpart_q, m2s_q;
  logic [63:0] b_d, b_q, x_d, x_q;
  logic signed [63:0] x_s;
  logic signed [16:0] p1s;
  logic signed [80:0] y_full;
  logic [63:0] y_q, pp_d, pp_q;
  logic [20:0] pr;
  logic [79:0] n_full;
  logic [63:0] n_q;
  logic [RemW-1:0] dv_q;
  logic zero_q;
  div_word_t word_d, word_q;

  // stage valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FrontLat-2:0], vld_i};
    end
  end

  // temperature differences and first products
  assign d1    = $signed({1'b0, adc_t0_q[19:3]}) - $signed({1'b0, coeff_i.t1, 1'b0});
  assign d2    = $signed({1'b0, adc_t0_q[19:4]}) - $signed({1'b0, coeff_i.t1});
  assign mt2_d = d1 * $signed(coeff_i.t2);
  assign sqt_d = d2 * d2;

  // square term times T3
  assign sqs   = sqt_q[33:12];
  assign m3t_d = sqs * $signed(coeff_i.t3);

  // fine temperature
  assign bt     = m3t_q[37:14];
  assign fine_d = {{2{at_q[22]}}, at_q} + {bt[23], bt};

  // output temperature and pressure offset
  assign t5     = {{1{fine_q[24]}}, fine_q, 2'b00} + {{3{fine_q[24]}}, fine_q} + TEMP_ROUND;
  assign temp_d = {{12{t5[27]}}, t5[27:8]};
  assign pa_d   = {fine_q[24], fine_q} - FINE_OFFSET;

  // products of the pressure offset
  assign sqp_d = pa_q * pa_q;
  assign m5_d  = pa_q * $signed(coeff_i.p5);
  assign m2_d  = pa_q * $signed(coeff_i.p2);

  // square term times P6 and P3, shifted terms
  assign m6_full = sqp_q * $signed(coeff_i.p6);
  assign m3_full = sqp_q * $signed(coeff_i.p3);
  assign bpart_d = {{5{m5_q[41]}}, m5_q, 17'b0} +
                   {{13{coeff_i.p4[15]}}, coeff_i.p4, 35'b0};

  // sum the numerator offset and the divisor base
  assign b_d = m6_q + bpart_q;
  assign x_d = DIV_BIAS + {{8{m3_q[63]}}, m3_q[63:8]} + m2s_q;

  // divisor scale by P1, dividend base
  assign x_s    = x_q;
  assign p1s    = {1'b0, coeff_i.p1};
  assign y_full = x_s * p1s;
  assign pr     = PRESS_FULL - {1'b0, adc_p7_q};
  assign pp_d   = {12'b0, pr, 31'b0} - b_q;

  // dividend scale
  assign n_full = pp_q * {4'b0, PRESS_SCALE};

  // signs and magnitudes for the divider
  always_comb begin
    word_d      = '0;
    word_d.neg  = n_q[63] ^ dv_q[RemW-1];
    word_d.dvd  = n_q[63] ? (64'd0 - n_q) : n_q;
    word_d.dsr  = dv_q[RemW-1] ? (RemW'(0) - dv_q) : dv_q;
    word_d.rem  = '0;
    word_d.zero = zero_q;
    word_d.temp = temp9_q;
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    adc_p0_q <= raw_pressure_i;
    adc_t0_q <= raw_temperature_i;
    adc_p1_q <= adc_p0_q;
    mt2_q    <= mt2_d;
    sqt_q    <= sqt_d;
    adc_p2_q <= adc_p1_q;
    at_q     <= mt2_q[33:11];
    m3t_q    <= m3t_d;
    adc_p3_q <= adc_p2_q;
    fine_q   <= fine_d;
    adc_p4_q <= adc_p3_q;
    temp4_q  <= temp_d;
    pa_q     <= pa_d;
    adc_p5_q <= adc_p4_q;
    temp5_q  <= temp4_q;
    sqp_q    <= sqp_d;
    m5_q     <= m5_d;
    m2_q     <= m2_d;
    adc_p6_q <= adc_p5_q;
    temp6_q  <= temp5_q;
    m6_q     <= m6_full[63:0];
    m3_q     <= m3_full[63:0];
    bpart_q  <= bpart_d;
    m2s_q    <= {{10{m2_q[41]}}, m2_q, 12'b0};
    adc_p7_q <= adc_p6_q;
    temp7_q  <= temp6_q;
    b_q      <= b_d;
    x_q      <= x_d;
    temp8_q  <= temp7_q;
    y_q      <= y_full[63:0];
    pp_q     <= pp_d;
    temp9_q  <= temp8_q;
    dv_q     <= y_q[63:33];
    zero_q   <= (y_q[63:33] == '0);
    n_q      <= n_full[63:0];
    word_q   <= word_d;
  end

  assign vld_o  = vld_q[FrontLat-1];
  assign word_o = word_q;

endmodule

// ----- rtl/ptc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ptc_pkg; sits between ptc_front and ptc_back.
module ptc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  ptc_pkg::div_word_t word_i,
  output logic               vld_o,
  output ptc_pkg::div_word_t word_o
);
  import ptc_pkg::*;

  logic      vin   [DivSteps];
  logic      vld_q [DivSteps];
  div_word_t stg_in[DivSteps];
  div_word_t stg_q [DivSteps];

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic [RemW:0] trial;
    logic          ge;
    div_word_t     nxt;

    if (i == 0) begin : g_first
      assign stg_in[i] = word_i;
      assign vin[i]    = vld_i;
    end else begin : g_next
      assign stg_in[i] = stg_q[i-1];
      assign vin[i]    = vld_q[i-1];
    end

    // trial subtract of the divisor from the shifted remainder
    assign trial = {stg_in[i].rem, stg_in[i].dvd[DivW-1]};
    assign ge    = trial >= {1'b0, stg_in[i].dsr};

    always_comb begin
      nxt     = stg_in[i];
      nxt.rem = ge ? RemW'(trial - {1'b0, stg_in[i].dsr}) : trial[RemW-1:0];
      nxt.dvd = {stg_in[i].dvd[DivW-2:0], ge};
    end

    // advance valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vin[i];
      end
    end

    // advance word
    always_ff @(posedge clk_i) begin
      stg_q[i] <= nxt;
    end
  end

  assign vld_o  = vld_q[DivSteps-1];
  assign word_o = stg_q[DivSteps-1];

endmodule

// ----- rtl/ptc_back.sv -----
// Pressure correction after the divide: P7, P8 and P9 terms (6 stages).
// Depends on ptc_pkg; fed by ptc_div.
module ptc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  ptc_pkg::div_word_t word_i,
  input  ptc_pkg::coeff_t    coeff_i,
  output logic               done_o,
  output logic [31:0]        temp_o,
  output logic [31:0]        press_o,
  output logic               invalid_o
);
  import ptc_pkg::*;

  logic [BackLat-2:0] vld_q;
  logic [BackLat-2:0] zero_q;
  logic [31:0] temp1_q, temp2_q, temp3_q, temp4_q, temp5_q;

  logic [63:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [50:0] s;
  logic signed [66:0] m9_full;
  logic signed [79:0] mb_full;
  logic signed [63:0] p_s;
  logic [63:0] m9_q, se_q, mb2_q, mb3_q, mb4_q;
  logic [63:0] ll_q, prod_d, prod_q, sum_d, sum_q;
  logic [31:0] hl_q, lh_q, press_d;
  logic [63:0] se_d;

  // valid chain, one bit per stage ahead of the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[BackLat-3:0], vld_i};
    end
  end

  // P9 and P8 products of the quotient
  assign p_s     = p1_q;
  assign s       = p_s[63:13];
  assign se_d    = {{13{s[50]}}, s};
  assign m9_full = s * $signed(coeff_i.p9);
  assign mb_full = p_s * $signed(coeff_i.p8);

  // recombine the 64-bit low product from its partial products
  assign prod_d = ll_q + {hl_q + lh_q, 32'b0};

  // sum of the three pressure terms
  assign sum_d = p4_q + {{25{prod_q[63]}}, prod_q[63:25]} + {{19{mb4_q[63]}}, mb4_q[63:19]};

  // final scaling, offset by P7, force zero on an empty divisor
  assign press_d = zero_q[BackLat-2] ? 32'd0
                 : sum_q[39:8] + {{12{coeff_i.p7[15]}}, coeff_i.p7, 4'b0};

  always_ff @(posedge clk_i) begin
    // apply the quotient sign
    p1_q    <= word_i.neg ? (64'd0 - word_i.dvd) : word_i.dvd;
    zero_q  <= {zero_q[BackLat-3:0], word_i.zero};
    temp1_q <= word_i.temp;
    temp2_q <= temp1_q;
    temp3_q <= temp2_q;
    temp4_q <= temp3_q;
    temp5_q <= temp4_q;
    p2_q    <= p1_q;
    m9_q    <= m9_full[63:0];
    se_q    <= se_d;
    mb2_q   <= mb_full[63:0];
    p3_q    <= p2_q;
    mb3_q   <= mb2_q;
    ll_q    <= m9_q[31:0] * se_q[31:0];
    hl_q    <= 32'(m9_q[63:32] * se_q[31:0]);
    lh_q    <= 32'(m9_q[31:0] * se_q[63:32]);
    p4_q    <= p3_q;
    mb4_q   <= mb3_q;
    prod_q  <= prod_d;
    sum_q   <= sum_d;
    temp_o  <= temp5_q;
    press_o <= press_d;
  end

  // output strobe and flag, registered alongside the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o    <= 1'b0;
      invalid_o <= 1'b0;
    end else begin
      done_o    <= vld_q[BackLat-2];
      invalid_o <= vld_q[BackLat-2] & zero_q[BackLat-2];
    end
  end

endmodule

// ----- rtl/pressure_temp_compensation.sv -----
// Top level of the pressure/temperature compensation block.
// Depends on ptc_pkg, ptc_front, ptc_div and ptc_back.
//
// Usage:
//   Calibration words are written through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   (index 0 temperature T1..T3, 1 P1..P4, 2 P5..P8, 3 P9), only while no
//   sample is in flight. Writes take effect at the clock edge, no read-back.
//   A raw pressure/temperature pair is taken at each edge with start_i high;
//   busy_o stays low, so a new pair may be started every cycle.
//   Each result shows on the output ports for one cycle, marked by done_o,
//   after its start has run through all three sub-blocks. Throughput is one
//   pair per cycle; the 64-stage pipelined divider sets most of the latency.
//   pressure_invalid_o marks a zero divisor, with pressure forced to 0.
//   Results leave in start order and cannot be held off by the receiver.
//   Reset clears all calibration words and drops every sample in flight.
module pressure_temp_compensation (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [19:0]        raw_pressure_i,
  input  logic [19:0]        raw_temperature_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [63:0]        cfg_wdata_i,
  output logic               done_o,
  output logic signed [31:0] temperature_centi_o,
  output logic [31:0]        pressure_q24_8_o,
  output logic               pressure_invalid_o
);
  import ptc_pkg::*;

  logic [47:0] temp_coeffs_q;
  logic [63:0] press_a_q, press_b_q;
  logic [15:0] press_nine_q;
  coeff_t      coeff;

  logic      front_vld, div_vld;
  div_word_t front_word, div_word;
  logic [31:0] temp_out;

  // calibration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coeffs_q <= '0;
      press_a_q     <= '0;
      press_b_q     <= '0;
      press_nine_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TEMP:       temp_coeffs_q <= cfg_wdata_i[47:0];
        CFG_PRESS_A:    press_a_q     <= cfg_wdata_i;
        CFG_PRESS_B:    press_b_q     <= cfg_wdata_i;
        CFG_PRESS_NINE: press_nine_q  <= cfg_wdata_i[15:0];
        default:        press_nine_q  <= press_nine_q;
      endcase
    end
  end

  // unpack coefficients
  assign coeff.t1 = temp_coeffs_q[15:0];
  assign coeff.t2 = temp_coeffs_q[31:16];
  assign coeff.t3 = temp_coeffs_q[47:32];
  assign coeff.p1 = press_a_q[15:0];
  assign coeff.p2 = press_a_q[31:16];
  assign coeff.p3 = press_a_q[47:32];
  assign coeff.p4 = press_a_q[63:48];
  assign coeff.p5 = press_b_q[15:0];
  assign coeff.p6 = press_b_q[31:16];
  assign coeff.p7 = press_b_q[47:32];
  assign coeff.p8 = press_b_q[63:48];
  assign coeff.p9 = press_nine_q;

  assign busy_o = 1'b0;

  ptc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .vld_i             (start_i),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .coeff_i           (coeff),
    .vld_o             (front_vld),
    .word_o            (front_word)
  );

  ptc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (front_vld),
    .word_i (front_word),
    .vld_o  (div_vld),
    .word_o (div_word)
  );

  ptc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (div_vld),
    .word_i    (div_word),
    .coeff_i   (coeff),
    .done_o    (done_o),
    .temp_o    (temp_out),
    .press_o   (pressure_q24_8_o),
    .invalid_o (pressure_invalid_o)
  );

  assign temperature_centi_o = $signed(temp_out);

`ifndef SYNTHESIS
  // every result word traces back to a start exactly one latency earlier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Latency))
    else $error("result word without matching start");

  // a zero divisor always reports zero pressure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pressure_invalid_o |-> (pressure_q24_8_o == 32'd0))
    else $error("invalid pressure word not forced to zero");

  // the flag only rides on a result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pressure_invalid_o |-> done_o)
    else $error("invalid flag without result word");
`endif

endmodule

// ----- sim/tb_pressure_temp_compensation.sv -----
// Self-checking testbench for pressure_temp_compensation: directed table, then random words.
// Depends on ptc_pkg and the RTL of the block; predicts each result with a 64-bit wrapping model.
`timescale 1ns / 1ps

module tb_pressure_temp_compensation;
  import ptc_pkg::*;

  typedef struct packed {
    logic signed [31:0] temp;
    logic [31:0]        press;
    logic               inv;
  } comp_res_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [19:0] raw_p;
    logic [19:0] raw_t;
    logic        typed;
    comp_res_t   res;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [19:0]        raw_pressure_i = '0;
  logic [19:0]        raw_temperature_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [63:0]        cfg_wdata_i = '0;
  logic               done_o;
  logic signed [31:0] temperature_centi_o;
  logic [31:0]        pressure_q24_8_o;
  logic               pressure_invalid_o;

  // shadow calibration words
  logic [63:0] cal_temp, cal_pa, cal_pb, cal_nine;
  comp_res_t   expected_q[$];
  int unsigned n_accepted = 0;
  int unsigned n_errors = 0;
  int unsigned n_cycles = 0;
  logic        typed_row = 1'b0;
  comp_res_t   typed_res = '0;
  logic        idle_ok = 1'b1;

  pressure_temp_compensation u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .raw_pressure_i, .raw_temperature_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .done_o, .temperature_centi_o,
    .pressure_q24_8_o, .pressure_invalid_o
  );

  always #5 clk_i = ~clk_i;

  // sign-extend a 16-bit field
  function automatic logic signed [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // signed divide truncating toward zero, wrapping on overflow
  function automatic logic signed [63:0] div_trunc(input logic signed [63:0] n,
                                                   input logic signed [63:0] d);
    logic [63:0] un, ud, q;
    un = n[63] ? -n : n;
    ud = d[63] ? -d : d;
    q = un / ud;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  // compensated temperature and pressure for one raw pair
  function automatic comp_res_t compensate(input logic [19:0] rp, input logic [19:0] rt);
    logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] a, b, d, fine, pr;
    comp_res_t r;
    t1 = {48'b0, cal_temp[15:0]};
    t2 = sx16(cal_temp[31:16]);
    t3 = sx16(cal_temp[47:32]);
    p1 = {48'b0, cal_pa[15:0]};
    p2 = sx16(cal_pa[31:16]);
    p3 = sx16(cal_pa[47:32]);
    p4 = sx16(cal_pa[63:48]);
    p5 = sx16(cal_pb[15:0]);
    p6 = sx16(cal_pb[31:16]);
    p7 = sx16(cal_pb[47:32]);
    p8 = sx16(cal_pb[63:48]);
    p9 = sx16(cal_nine[15:0]);
    d = $signed({47'b0, rt[19:3]}) - (t1 <<< 1);
    a = (d * t2) >>> 11;
    d = $signed({48'b0, rt[19:4]}) - t1;
    b = (((d * d) >>> 12) * t3) >>> 14;
    fine = a + b;
    r.temp = 32'((fine * 64'sd5 + 64'sd128) >>> 8);
    a = fine - 64'sd128000;
    b = a * a * p6;
    b = b + ((a * p5) <<< 17);
    b = b + (p4 <<< 35);
    a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
    a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
    if (a == 0) begin
      r.press = '0;
      r.inv = 1'b1;
      return r;
    end
    pr = 64'sd1048576 - $signed({44'b0, rp});
    pr = div_trunc(((pr <<< 31) - b) * 64'sd3125, a);
    a = (p9 * (pr >>> 13) * (pr >>> 13)) >>> 25;
    b = (p8 * pr) >>> 19;
    pr = ((pr + a + b) >>> 8) + (p7 <<< 4);
    r.press = pr[31:0];
    r.inv = 1'b0;
    return r;
  endfunction

  // track writes and accepted words, queue the expected result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_temp = '0;
      cal_pa = '0;
      cal_pb = '0;
      cal_nine = '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TEMP:       cal_temp = {16'b0, cfg_wdata_i[47:0]};
          CFG_PRESS_A:    cal_pa = cfg_wdata_i;
          CFG_PRESS_B:    cal_pb = cfg_wdata_i;
          CFG_PRESS_NINE: cal_nine = {48'b0, cfg_wdata_i[15:0]};
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        expected_q.push_back(typed_row ? typed_res : compensate(raw_pressure_i,
                                                                raw_temperature_i));
        n_accepted++;
      end
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    comp_res_t e;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word temp=%0d press=%h inv=%b", $time,
                 temperature_centi_o, pressure_q24_8_o, pressure_invalid_o);
        n_errors++;
      end else begin
        e = expected_q.pop_front();
        if (temperature_centi_o !== e.temp) begin
          $display("%0t: temperature expected %0d actual %0d", $time, e.temp,
                   temperature_centi_o);
          n_errors++;
        end
        if (pressure_q24_8_o !== e.press) begin
          $display("%0t: pressure expected %h actual %h", $time, e.press, pressure_q24_8_o);
          n_errors++;
        end
        if (pressure_invalid_o !== e.inv) begin
          $display("%0t: invalid flag expected %b actual %b", $time, e.inv,
                   pressure_invalid_o);
          n_errors++;
        end
      end
    end
  end

  // stop a hung run
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > 400000) begin
      $display("[pressure_temp_compensation] ERROR");
      $finish;
    end
  end

  // wait for the pipeline to empty before touching calibration
  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic program_cal(input logic [15:0] t1, t2, t3, p1, p2, p3, p4,
                             input logic [15:0] p5, p6, p7, p8, p9);
    write_reg(CFG_TEMP, {16'($urandom), t3, t2, t1});
    write_reg(CFG_PRESS_A, {p4, p3, p2, p1});
    write_reg(CFG_PRESS_B, {p8, p7, p6, p5});
    write_reg(CFG_PRESS_NINE, {32'($urandom), 16'($urandom), p9});
  endtask

  // present one word at this falling edge and hold it until taken
  task automatic send_pair(input logic [19:0] rp, input logic [19:0] rt);
    int unsigned taken;
    taken = n_accepted;
    start_i <= 1'b1;
    raw_pressure_i <= rp;
    raw_temperature_i <= rt;
    do @(negedge clk_i); while (n_accepted == taken);
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      raw_pressure_i <= 20'($urandom);
      raw_temperature_i <= 20'($urandom);
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
  endtask

  task automatic load_phase(input int ph);
    case (ph)
      1: program_cal(16'd27504, 16'd26435, -16'sd1000, 16'd36477, -16'sd10685, 16'd3024,
                     16'd2855, 16'd140, -16'sd7, 16'd15500, -16'sd14600, 16'd6000);
      2: program_cal('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1);
      3: program_cal(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                     16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      4: program_cal(16'd27504, 16'd26435, -16'sd1000, 16'd0, -16'sd10685, 16'd3024,
                     16'd2855, 16'd140, -16'sd7, 16'd15500, -16'sd14600, 16'd6000);
      5: program_cal(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                     16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      default: ;
    endcase
  endtask

  // jitter a nominal coefficient
  function automatic logic [15:0] near(input int nominal, input int spread);
    return 16'(nominal + $urandom_range(0, 2 * spread) - spread);
  endfunction

  stim_row_t rows[$];

  initial begin
    int cur_phase;
    comp_res_t zero_cal;
    zero_cal = '{temp: 32'sd0, press: 32'd0, inv: 1'b1};
    // phase 0 runs on reset calibration: every result reads temp 0, invalid pressure
    rows = '{
      '{3'd0, 20'h00000, 20'h00000, 1'b1, zero_cal},
      '{3'd0, 20'hfffff, 20'hfffff, 1'b1, zero_cal},
      '{3'd0, 20'h80000, 20'h12345, 1'b1, zero_cal},
      '{3'd1, 20'h00000, 20'h00000, 1'b0, '0},
      '{3'd1, 20'hfffff, 20'hfffff, 1'b0, '0},
      '{3'd1, 20'd415148, 20'd519888, 1'b0, '0},
      '{3'd1, 20'h00000, 20'hfffff, 1'b0, '0},
      '{3'd1, 20'hfffff, 20'h00000, 1'b0, '0},
      '{3'd1, 20'haaaaa, 20'h55555, 1'b0, '0},
      '{3'd2, 20'h00000, 20'h00000, 1'b0, '0},
      '{3'd2, 20'hfffff, 20'hfffff, 1'b0, '0},
      '{3'd2, 20'h55555, 20'haaaaa, 1'b0, '0},
      '{3'd3, 20'h00000, 20'hfffff, 1'b0, '0},
      '{3'd3, 20'hfffff, 20'h00000, 1'b0, '0},
      '{3'd3, 20'h7ffff, 20'h80000, 1'b0, '0},
      '{3'd4, 20'd415148, 20'd519888, 1'b0, '0},
      '{3'd4, 20'hfffff, 20'h00000, 1'b0, '0},
      '{3'd5, 20'h00000, 20'h00000, 1'b0, '0},
      '{3'd5, 20'hfffff, 20'hfffff, 1'b0, '0},
      '{3'd5, 20'h12345, 20'hedcba, 1'b0, '0}
    };
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    cur_phase = 0;
    foreach (rows[i]) begin
      if (rows[i].phase != cur_phase) begin
        start_i <= 1'b0;
        drain();
        typed_row <= 1'b0;
        cur_phase = rows[i].phase;
        load_phase(cur_phase);
      end
      typed_row <= rows[i].typed;
      typed_res <= rows[i].res;
      send_pair(rows[i].raw_p, rows[i].raw_t);
    end
    start_i <= 1'b0;
    typed_row <= 1'b0;

    // random phases: half plausible calibration, the rest wild or extreme
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph % 4)
        0, 2: program_cal(near(27504, 3000), near(26435, 3000), near(-1000, 500),
                          near(36477, 3000), near(-10685, 2000), near(3024, 500),
                          near(2855, 500), near(140, 100), near(-7, 10),
                          near(15500, 2000), near(-14600, 2000), near(6000, 1000));
        1: program_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        default: program_cal(16'hffff, 16'h7fff, 16'h8000, 16'hffff, 16'h8000,
                             16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                             16'h8000, 16'h7fff);
      endcase
      // no idling over the last stretch
      idle_ok = (ph < 7);
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(0, 3) == 0)
          send_pair(20'($urandom), 20'($urandom));
        else
          send_pair(20'($urandom_range(200000, 700000)), 20'($urandom_range(300000, 700000)));
      end
      start_i <= 1'b0;
    end

    // let the pipeline empty, then report
    drain();
    if (n_errors == 0) begin
      $display("[pressure_temp_compensation] OK");
    end else begin
      $display("[pressure_temp_compensation] ERROR");
    end
    $finish;
  end

endmodule
